### hw/rtl/file_uri_percent_decoder_unit_assert.svh
// Assertion macros for the file URI percent decoder unit.
// Included by the top level; needs no package.
`ifndef FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH
`define FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fupd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FUPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fupd assertion failed");

`endif

### hw/rtl/fupd_pkg.sv
// Shared types, constants and decode functions of the file URI percent decoder.
// Used by every module of the unit; depends on nothing.
`timescale 1ns / 1ps

package fupd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic       last;
    logic [2:0] pre_cnt;
    logic [1:0] tail_cnt;
    logic [7:0] tail0;
    logic [7:0] tail1;
  } cmd_t;

  typedef enum logic [2:0] {
    EscIdle   = 3'b001,
    EscFirst  = 3'b010,
    EscSecond = 3'b100
  } esc_phase_e;

  localparam logic [2:0] PrefixDone  = 3'd7;
  localparam logic [7:0] PercentChar = 8'h25;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6c;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h3a;
      3'd5:    ch = 8'h2f;
      3'd6:    ch = 8'h2f;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Returns {valid, value} of one hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Two-character field read as a base-16 number with optional lead, wrapped to a byte.
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic [7:0] r;
    va = hex_value(a);
    vb = hex_value(b);
    r  = 8'h00;
    if (va[4]) begin
      r = vb[4] ? {va[3:0], vb[3:0]} : {4'h0, va[3:0]};
    end else if (vb[4]) begin
      if (is_space(a) || a == 8'h2b) begin
        r = {4'h0, vb[3:0]};
      end else if (a == 8'h2d) begin
        r = 8'h00 - {4'h0, vb[3:0]};
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/fupd_front.sv
// Front end: tracks the prefix match and escape state and turns each input
// transfer into at most one output command. Depends on fupd_pkg.
`timescale 1ns / 1ps

module fupd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  fupd_pkg::in_t   in_i,
  output logic            push_o,
  output fupd_pkg::cmd_t  cmd_o
);

  logic [2:0]            pos_q, pos_d;
  fupd_pkg::esc_phase_e  phase_q, phase_d;
  logic [7:0]            first_q, first_d;
  logic                  run_dec;
  logic                  dec_has;
  logic [7:0]            dec_byte;
  logic [7:0]            c;
  logic                  last;

  always_comb begin
    c        = in_i.in_byte;
    last     = in_i.in_last;
    pos_d    = pos_q;
    phase_d  = phase_q;
    first_d  = first_q;
    run_dec  = 1'b0;
    dec_has  = 1'b0;
    dec_byte = c;
    cmd_o    = '0;
    cmd_o.last = last;

    if (pos_q != fupd_pkg::PrefixDone) begin
      if (c == fupd_pkg::prefix_char(pos_q)) begin
        pos_d = pos_q + 3'd1;
        if (last && pos_d != fupd_pkg::PrefixDone) begin
          cmd_o.pre_cnt = pos_d;
        end
      end else begin
        cmd_o.pre_cnt = pos_q;
        pos_d         = fupd_pkg::PrefixDone;
        run_dec       = 1'b1;
      end
    end else begin
      run_dec = 1'b1;
    end

    if (run_dec) begin
      unique case (phase_q)
        fupd_pkg::EscFirst: begin
          first_d = c;
          phase_d = fupd_pkg::EscSecond;
        end
        fupd_pkg::EscSecond: begin
          dec_has  = 1'b1;
          dec_byte = fupd_pkg::decode_pair(first_q, c);
          phase_d  = fupd_pkg::EscIdle;
          first_d  = 8'h00;
        end
        default: begin
          if (c == fupd_pkg::PercentChar) begin
            phase_d = fupd_pkg::EscFirst;
          end else begin
            phase_d = fupd_pkg::EscIdle;
            dec_has = 1'b1;
          end
        end
      endcase
    end

    if (dec_has) begin
      cmd_o.tail_cnt = 2'd1;
      cmd_o.tail0    = dec_byte;
    end else if (last && phase_d == fupd_pkg::EscFirst) begin
      cmd_o.tail_cnt = 2'd1;
      cmd_o.tail0    = fupd_pkg::PercentChar;
    end else if (last && phase_d == fupd_pkg::EscSecond) begin
      cmd_o.tail_cnt = 2'd2;
      cmd_o.tail0    = fupd_pkg::PercentChar;
      cmd_o.tail1    = first_d;
    end

    if (last) begin
      pos_d   = 3'd0;
      phase_d = fupd_pkg::EscIdle;
      first_d = 8'h00;
    end

    push_o = accept_i && (last || cmd_o.pre_cnt != 3'd0 || cmd_o.tail_cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      phase_q <= fupd_pkg::EscIdle;
      first_q <= 8'h00;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

endmodule

### hw/rtl/fupd_cmd_fifo.sv
// Command queue between the front and back ends of the decoder.
// Depends on fupd_pkg for the command type.
`timescale 1ns / 1ps

module fupd_cmd_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fupd_pkg::cmd_t  data_i,
  input  logic            pop_i,
  output fupd_pkg::cmd_t  data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fupd_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### hw/rtl/fupd_back.sv
// Back end: expands each queued command into result transfers, one per cycle while the
// output is not stalled, through a registered output stage. Depends on fupd_pkg.
`timescale 1ns / 1ps

module fupd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  fupd_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fupd_pkg::out_t  out_o
);

  logic [2:0]      idx_q;
  logic            out_valid_q;
  fupd_pkg::out_t  out_q;
  logic [3:0]      total;
  logic [3:0]      n_res;
  logic            final_res;
  logic            load;
  logic [2:0]      off;
  fupd_pkg::out_t  res;

  always_comb begin
    total     = {1'b0, cmd_i.pre_cnt} + {2'b00, cmd_i.tail_cnt};
    n_res     = (total == 4'd0) ? 4'd1 : total;
    final_res = ({1'b0, idx_q} == n_res - 4'd1);
    off       = idx_q - cmd_i.pre_cnt;
    res       = '0;
    if (total != 4'd0) begin
      res.has_byte = 1'b1;
      if (idx_q < cmd_i.pre_cnt) begin
        res.out_byte = fupd_pkg::prefix_char(idx_q);
      end else begin
        res.out_byte = off[0] ? cmd_i.tail1 : cmd_i.tail0;
      end
    end
    res.out_last = cmd_i.last && final_res;
  end

  assign load        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && final_res;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_res ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/file_uri_percent_decoder_unit.sv
// The first result of an input transfer passes through the command queue and the registered
// result stage. Throughput: one input per cycle while each input yields at most one result
// and the output is not stalled; an input with several results holds the result stage
// until all are out, and the command queue absorbs that. The result stage emits one result
// per cycle unless stalled and sets the rate. Reset (rst_ni low, asynchronous) clears
// prefix and escape state, empties the queue and drops the output valid.
`timescale 1ns / 1ps
`include "file_uri_percent_decoder_unit_assert.svh"

module file_uri_percent_decoder_unit #(
  parameter int FifoDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fupd_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fupd_pkg::out_t  out_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            fifo_full;
  logic            fifo_empty;
  fupd_pkg::cmd_t  cmd_in;
  fupd_pkg::cmd_t  cmd_head;

  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  fupd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  fupd_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  fupd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!fifo_empty),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  `FUPD_ASSERT_IMPL(a_last_pushes, clk_i, rst_ni, accept && in_i.in_last, push)
  `FUPD_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !fifo_empty)
  `FUPD_ASSERT_IMPL(a_bare_marker, clk_i, rst_ni, out_valid_o && !out_o.has_byte, out_o.out_last && out_o.out_byte == 8'h00)
  `FUPD_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push && !pop, !fifo_empty)

endmodule

### tb/testbench.sv
// Self-checking testbench for the file URI percent decoder unit.
// Depends on fupd_pkg and file_uri_percent_decoder_unit; streams URI strings and checks
// every decoded result against a cycle-free model of the prefix stripper and decoder.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic          drain;
    fupd_pkg::in_t data;
  } uri_item_t;

  localparam logic [55:0] SchemeText = "file://";
  localparam logic [7:0]  PlusChar   = 8'h2b;
  localparam logic [7:0]  MinusChar  = 8'h2d;
  localparam string       HexDigits  = "0123456789abcdefABCDEF";
  localparam string       LeadChars  = " \t\n\v\f\r+-0";

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  fupd_pkg::in_t  in_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  fupd_pkg::out_t out_o;

  uri_item_t           uri_q[$];
  fupd_pkg::out_t      path_q[$];
  int                  accepted_cnt = 0;
  int                  mismatch_cnt = 0;
  logic                calm;

  logic [2:0]           scheme_len = 3'd0;
  fupd_pkg::esc_phase_e esc_state = fupd_pkg::EscIdle;
  logic [7:0]           esc_lead = 8'h00;

  assign calm = accepted_cnt >= 200 && accepted_cnt < 330;

  file_uri_percent_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    return SchemeText[8 * (6 - idx) +: 8];
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    case (c) inside
      [8'h30:8'h39]: return {1'b1, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: return {1'b1, c[3:0] + 4'd9};
      default: return 5'h00;
    endcase
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] da;
    logic [4:0] db;
    da = hex_digit(a);
    db = hex_digit(b);
    if (da[4]) return db[4] ? {da[3:0], db[3:0]} : {4'h0, da[3:0]};
    if (!db[4]) return 8'h00;
    if (a == PlusChar || a == 8'h20 || (a >= 8'h09 && a <= 8'h0d)) return {4'h0, db[3:0]};
    if (a == MinusChar) return 8'h00 - {4'h0, db[3:0]};
    return 8'h00;
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    path_q.push_back('{out_byte: c, has_byte: 1'b1, out_last: 1'b0});
  endfunction

  function automatic void release_scheme(input logic [2:0] held);
    for (int i = 0; i < held; i++) emit_char(scheme_char(3'(i)));
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    if (esc_state == fupd_pkg::EscFirst) begin
      esc_lead  = c;
      esc_state = fupd_pkg::EscSecond;
    end else if (esc_state == fupd_pkg::EscSecond) begin
      emit_char(pair_value(esc_lead, c));
      esc_state = fupd_pkg::EscIdle;
      esc_lead  = 8'h00;
    end else if (c == fupd_pkg::PercentChar) begin
      esc_state = fupd_pkg::EscFirst;
    end else begin
      emit_char(c);
    end
  endfunction

  function automatic void predict_path(input fupd_pkg::in_t it);
    int base;
    base = path_q.size();
    if (scheme_len < fupd_pkg::PrefixDone) begin
      if (it.in_byte == scheme_char(scheme_len)) begin
        scheme_len++;
        if (it.in_last && scheme_len < fupd_pkg::PrefixDone) release_scheme(scheme_len);
      end else begin
        release_scheme(scheme_len);
        scheme_len = fupd_pkg::PrefixDone;
        decode_char(it.in_byte);
      end
    end else begin
      decode_char(it.in_byte);
    end
    if (it.in_last) begin
      if (esc_state == fupd_pkg::EscFirst) begin
        emit_char(fupd_pkg::PercentChar);
      end else if (esc_state == fupd_pkg::EscSecond) begin
        emit_char(fupd_pkg::PercentChar);
        emit_char(esc_lead);
      end
      if (path_q.size() == base) begin
        path_q.push_back('{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1});
      end else begin
        path_q[path_q.size() - 1].out_last = 1'b1;
      end
      scheme_len = 3'd0;
      esc_state  = fupd_pkg::EscIdle;
      esc_lead   = 8'h00;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic push_bytes(input logic [7:0] txt[$], input logic drain);
    for (int i = 0; i < txt.size(); i++) begin
      uri_q.push_back('{drain: drain && i == 0,
                        data: '{in_byte: txt[i], in_last: i == txt.size() - 1}});
    end
  endtask

  task automatic push_text(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    push_bytes(txt, 1'b0);
  endtask

  task automatic push_random_uri(input logic drain);
    logic [7:0] txt[$];
    int         kind;
    int         cut;
    kind = $urandom_range(99);
    if (kind < 40) begin
      for (int i = 0; i < 7; i++) txt.push_back(scheme_char(3'(i)));
    end else if (kind < 55) begin
      for (int i = 0; i < 7; i++) txt.push_back(scheme_char(3'(i)));
      txt.push_back(8'h2f);
    end else if (kind < 75) begin
      cut = $urandom_range(6, 1);
      for (int i = 0; i < cut; i++) txt.push_back(scheme_char(3'(i)));
    end
    repeat ($urandom_range(12, 0)) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        txt.push_back(8'($urandom_range(255, 1)));
      end else if (kind < 45) begin
        txt.push_back(8'($urandom_range(8'h7e, 8'h20)));
      end else if (kind < 75) begin
        txt.push_back(fupd_pkg::PercentChar);
        txt.push_back(HexDigits[$urandom_range(21)]);
        txt.push_back(HexDigits[$urandom_range(21)]);
      end else if (kind < 85) begin
        txt.push_back(fupd_pkg::PercentChar);
        txt.push_back(LeadChars[$urandom_range(LeadChars.len() - 1)]);
        if ($urandom_range(3) != 0) txt.push_back(HexDigits[$urandom_range(21)]);
        else txt.push_back(8'($urandom_range(255, 1)));
      end else if (kind < 95) begin
        txt.push_back(fupd_pkg::PercentChar);
        txt.push_back(8'($urandom_range(255, 1)));
        txt.push_back(8'($urandom_range(255, 1)));
      end else begin
        txt.push_back(fupd_pkg::PercentChar);
      end
    end
    if (txt.size() == 0) txt.push_back(8'($urandom_range(255, 1)));
    push_bytes(txt, drain);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    uri_item_t nxt;
    logic      go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_path(in_i);
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        go = uri_q.size() != 0 && (calm || $urandom_range(99) >= 26);
        if (go && uri_q[0].drain && path_q.size() != 0) go = 1'b0;
        if (go) begin
          nxt = uri_q.pop_front();
          in_valid_i <= 1'b1;
          in_i       <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    fupd_pkg::out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (path_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", out_o));
        end else begin
          want = path_q.pop_front();
          if (out_o.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %h, want %h", out_o.out_byte, want.out_byte));
          end
          if (out_o.has_byte !== want.has_byte) begin
            report_mismatch($sformatf("has_byte %b, want %b", out_o.has_byte, want.has_byte));
          end
          if (out_o.out_last !== want.out_last) begin
            report_mismatch($sformatf("out_last %b, want %b", out_o.out_last, want.out_last));
          end
        end
      end
      out_ready_i <= calm || $urandom_range(99) >= 26;
    end
  end

  initial begin
    push_text("file://");
    push_text("file:/A");
    push_text("fi");
    push_text("% a%-5%0X%4");
    push_random_uri(1'b1);
    while (uri_q.size() < 520) push_random_uri(uri_q.size() > 260 && uri_q.size() < 275);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (uri_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (path_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### file_uri_percent_decoder_unit.f
+incdir+hw/rtl
hw/rtl/fupd_pkg.sv
hw/rtl/fupd_front.sv
hw/rtl/fupd_cmd_fifo.sv
hw/rtl/fupd_back.sv
hw/rtl/file_uri_percent_decoder_unit.sv
tb/testbench.sv
